// File: hdl/assert_macros.svh
// Assertion macros shared by the error history stack RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/ohes_pkg.sv
// Types and constants of the overwriting error history stack
package ohes_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [CNT_W-1:0]  count_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_DUMP   = 3'd3,
    OP_READ   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_STATUS = 3'd6
  } op_e;

  // Cell commands: hold, shift toward the deep end, toward the top, rotate, clear
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_DN,
    CELL_SHIFT_UP,
    CELL_ROTATE,
    CELL_CLEAR
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    code_t     new_code;
  } chain_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

endpackage

// File: hdl/ohes_cell.sv
// One storage cell of the stack chain
module ohes_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ohes_pkg::cell_cmd_e  cmd_i,
  input  ohes_pkg::code_t      prev_code_i,
  input  logic                 prev_valid_i,
  input  ohes_pkg::code_t      next_code_i,
  input  logic                 next_valid_i,
  output ohes_pkg::code_t      code_o,
  output logic                 valid_o,
  output ohes_pkg::code_t      tap_o
);

  ohes_pkg::code_t code_q, code_d;
  logic            valid_q, valid_d;

  always_comb begin
    code_d  = code_q;
    valid_d = valid_q;
    case (cmd_i)
      ohes_pkg::CELL_HOLD: begin
      end
      ohes_pkg::CELL_SHIFT_DN: begin
        code_d  = prev_code_i;
        valid_d = prev_valid_i;
      end
      ohes_pkg::CELL_SHIFT_UP: begin
        code_d  = next_code_i;
        valid_d = next_valid_i;
      end
      ohes_pkg::CELL_ROTATE: begin
        code_d = prev_code_i;
      end
      ohes_pkg::CELL_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
  end

  // oldest held entry: valid with nothing valid below it
  assign tap_o   = (valid_q && !next_valid_i) ? code_q : '0;
  assign code_o  = code_q;
  assign valid_o = valid_q;

endmodule

// File: hdl/ohes_chain.sv
// Row of stack cells, newest entry at cell 0
module ohes_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ohes_pkg::chain_ctrl_t     ctrl_i,
  output ohes_pkg::code_t           newest_o,
  output ohes_pkg::code_t           oldest_o,
  output logic [ohes_pkg::DEPTH-1:0] valid_o
);

  ohes_pkg::code_t code_w [ohes_pkg::DEPTH];
  ohes_pkg::code_t tap_w  [ohes_pkg::DEPTH];
  logic [ohes_pkg::DEPTH-1:0] valid_w;
  ohes_pkg::code_t top_feed;

  // push feeds the new code, rotation feeds the oldest back in
  assign top_feed = (ctrl_i.cmd == ohes_pkg::CELL_SHIFT_DN) ? ctrl_i.new_code : oldest_o;

  for (genvar i = 0; i < ohes_pkg::DEPTH; i++) begin : g_cell
    ohes_pkg::code_t prev_code, next_code;
    logic            prev_valid, next_valid;

    if (i == 0) begin : g_first
      assign prev_code  = top_feed;
      assign prev_valid = 1'b1;
    end else begin : g_mid
      assign prev_code  = code_w[i-1];
      assign prev_valid = valid_w[i-1];
    end

    if (i == ohes_pkg::DEPTH - 1) begin : g_last
      assign next_code  = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_code  = code_w[i+1];
      assign next_valid = valid_w[i+1];
    end

    ohes_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (ctrl_i.cmd),
      .prev_code_i  (prev_code),
      .prev_valid_i (prev_valid),
      .next_code_i  (next_code),
      .next_valid_i (next_valid),
      .code_o       (code_w[i]),
      .valid_o      (valid_w[i]),
      .tap_o        (tap_w[i])
    );
  end

  always_comb begin
    oldest_o = '0;
    for (int i = 0; i < ohes_pkg::DEPTH; i++) begin
      oldest_o = oldest_o | tap_w[i];
    end
  end

  assign newest_o = code_w[0];
  assign valid_o  = valid_w;

endmodule

// File: hdl/overwriting_error_history_stack_top.sv
// Top level of the overwriting error history stack
//
//  channel | direction | handshake               | payload
//  in      | in        | in_valid_i / in_ready_o  | op_i, new_code_i
//  out     | out       | out_valid_o / out_ready_i | code_out_o, found_o, last_o, empty_res_o
//
// Push, pop, peek, clear and status complete on the accepting transfer.
// Dump and read of a non-empty stack stream out one result per held code
// (1 to DEPTH), paced by the output register; the chain rotates once per
// emitted code, but dump clears it on the last. On an empty stack they give one result.
// No input transfer is taken while a dump or read is streaming.
// Reset empties the stack; stored codes are not cleared.
// A stalled output holds the chain, the stream and the input.
`include "assert_macros.svh"

module overwriting_error_history_stack_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [15:0] new_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_out_o,
  output logic        found_o,
  output logic        last_o,
  output logic        empty_res_o
);

  localparam ohes_pkg::count_t Full = ohes_pkg::count_t'(ohes_pkg::DEPTH);
  localparam ohes_pkg::count_t One  = ohes_pkg::count_t'(1);

  ohes_pkg::state_e      state_q, state_d;
  ohes_pkg::count_t      count_q, count_d;
  ohes_pkg::count_t      rem_q, rem_d;
  logic                  dump_q, dump_d;
  ohes_pkg::op_e         op;
  ohes_pkg::chain_ctrl_t ctrl;
  ohes_pkg::code_t       newest, oldest;
  logic [ohes_pkg::DEPTH-1:0] valid;

  logic            out_valid_q;
  ohes_pkg::code_t res_code_q, res_code_d;
  logic            res_found_q, res_found_d;
  logic            res_last_q, res_last_d;
  logic            res_empty_q, res_empty_d;
  logic            load;
  logic            out_free;
  logic            accept;
  logic            push_grow;

  assign op       = ohes_pkg::op_e'(op_i);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ohes_pkg::ST_IDLE) && out_free;
  assign accept   = in_valid_i && in_ready_o;
  assign push_grow = accept && (op == ohes_pkg::OP_PUSH) && (count_q != Full);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ohes_pkg::ST_IDLE: begin
        if (accept && (op == ohes_pkg::OP_DUMP || op == ohes_pkg::OP_READ) &&
            count_q != '0) begin
          state_d = ohes_pkg::ST_STREAM;
        end
      end
      ohes_pkg::ST_STREAM: begin
        if (out_free && rem_q == One) begin
          state_d = ohes_pkg::ST_IDLE;
        end
      end
      default: state_d = ohes_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.cmd      = ohes_pkg::CELL_HOLD;
    ctrl.new_code = new_code_i;
    load          = 1'b0;
    res_code_d    = '0;
    res_found_d   = 1'b0;
    res_last_d    = 1'b1;
    res_empty_d   = 1'b1;
    count_d       = count_q;
    rem_d         = rem_q;
    dump_d        = dump_q;
    case (state_q)
      ohes_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            ohes_pkg::OP_PUSH: begin
              ctrl.cmd = ohes_pkg::CELL_SHIFT_DN;
              if (count_q != Full) count_d = count_q + One;
            end
            ohes_pkg::OP_POP: begin
              load = 1'b1;
              if (count_q != '0) begin
                ctrl.cmd    = ohes_pkg::CELL_SHIFT_UP;
                res_code_d  = newest;
                res_found_d = 1'b1;
                res_empty_d = (count_q == One);
                count_d     = count_q - One;
              end
            end
            ohes_pkg::OP_PEEK: begin
              load = 1'b1;
              if (count_q != '0) begin
                res_code_d  = newest;
                res_found_d = 1'b1;
                res_empty_d = 1'b0;
              end
            end
            ohes_pkg::OP_DUMP, ohes_pkg::OP_READ: begin
              if (count_q == '0) begin
                load = 1'b1;
              end else begin
                rem_d  = count_q;
                dump_d = (op == ohes_pkg::OP_DUMP);
              end
            end
            ohes_pkg::OP_CLEAR: begin
              ctrl.cmd = ohes_pkg::CELL_CLEAR;
              count_d  = '0;
            end
            ohes_pkg::OP_STATUS: begin
              load        = 1'b1;
              res_empty_d = (count_q == '0);
            end
            default: begin
            end
          endcase
        end
      end
      ohes_pkg::ST_STREAM: begin
        if (out_free) begin
          load        = 1'b1;
          res_code_d  = oldest;
          res_found_d = 1'b1;
          res_last_d  = (rem_q == One);
          res_empty_d = dump_q;
          rem_d       = rem_q - One;
          if (rem_q == One && dump_q) begin
            ctrl.cmd = ohes_pkg::CELL_CLEAR;
            count_d  = '0;
          end else begin
            ctrl.cmd = ohes_pkg::CELL_ROTATE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  ohes_chain u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .newest_o (newest),
    .oldest_o (oldest),
    .valid_o  (valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ohes_pkg::ST_IDLE;
      count_q     <= '0;
      rem_q       <= '0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      dump_q  <= dump_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_code_q  <= res_code_d;
      res_found_q <= res_found_d;
      res_last_q  <= res_last_d;
      res_empty_q <= res_empty_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_out_o  = res_code_q;
  assign found_o     = res_found_q;
  assign last_o      = res_last_q;
  assign empty_res_o = res_empty_q;

  `ASSERT_CLK(a_count_range, (count_q <= Full), "fill count above depth")
  `ASSERT_CLK(a_valid_count, (ohes_pkg::count_t'($countones(valid)) == count_q), "valid count")
  `ASSERT_IMP(a_stream_rem, (state_q == ohes_pkg::ST_STREAM), (rem_q != '0), "empty stream")
  `ASSERT_IMP(a_not_found_zero, (out_valid_o && !found_o), (code_out_o == '0), "code set")
  `ASSERT_CLK(a_push_count, (push_grow |=> (count_q == $past(count_q) + One)), "push count")

endmodule

// File: tb/overwriting_error_history_stack_top_tb.sv
// Self-checking testbench for the overwriting error history stack top level
`timescale 1ns / 100ps

module overwriting_error_history_stack_top_tb;

  localparam logic [2:0]  OP_UNUSED    = 3'd7;
  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RAND_ITEMS   = 100;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned IDX_W        = $clog2(ohes_pkg::DEPTH);

  typedef struct packed {
    ohes_pkg::code_t code;
    logic            found;
    logic            last;
    logic            empty;
  } err_result_t;

  class ErrHistScoreboard;
    ohes_pkg::code_t   code_mem [ohes_pkg::DEPTH];
    logic [IDX_W-1:0]  top_idx;
    ohes_pkg::count_t  held;
    err_result_t       pending_q [$];
    int unsigned       errors;

    function new();
      top_idx = '0;
      held    = '0;
      errors  = 0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function logic [IDX_W-1:0] wrap_inc(logic [IDX_W-1:0] i);
      return (i == IDX_W'(ohes_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function void push_result(ohes_pkg::code_t code, logic found, logic last, logic empty);
      err_result_t r;
      r.code  = code;
      r.found = found;
      r.last  = last;
      r.empty = empty;
      pending_q.push_back(r);
    endfunction

    // Works out the results caused by one accepted transfer
    function void note_input(logic [2:0] op, ohes_pkg::code_t code);
      logic [IDX_W-1:0] idx;
      int unsigned      n;
      case (op)
        ohes_pkg::OP_PUSH: begin
          code_mem[top_idx] = code;
          top_idx = wrap_inc(top_idx);
          if (held < ohes_pkg::count_t'(ohes_pkg::DEPTH)) held++;
        end
        ohes_pkg::OP_POP, ohes_pkg::OP_PEEK: begin
          if (held == 0) begin
            push_result('0, 1'b0, 1'b1, 1'b1);
          end else begin
            idx = (top_idx == '0) ? IDX_W'(ohes_pkg::DEPTH - 1) : top_idx - 1'b1;
            if (op == ohes_pkg::OP_POP) begin
              held--;
              top_idx = idx;
            end
            push_result(code_mem[idx], 1'b1, 1'b1, held == 0);
          end
        end
        ohes_pkg::OP_DUMP, ohes_pkg::OP_READ: begin
          if (held == 0) begin
            push_result('0, 1'b0, 1'b1, 1'b1);
          end else begin
            n   = held;
            idx = IDX_W'((int'(top_idx) + ohes_pkg::DEPTH - n) % ohes_pkg::DEPTH);
            for (int unsigned i = 0; i < n; i++) begin
              push_result(code_mem[idx], 1'b1, i + 1 == n, op == ohes_pkg::OP_DUMP);
              idx = wrap_inc(idx);
            end
            if (op == ohes_pkg::OP_DUMP) begin
              held    = '0;
              top_idx = '0;
            end
          end
        end
        ohes_pkg::OP_CLEAR: begin
          held    = '0;
          top_idx = '0;
        end
        ohes_pkg::OP_STATUS: push_result('0, 1'b0, 1'b1, held == 0);
        default: ;
      endcase
    endfunction

    task check_result(ohes_pkg::code_t code, logic found, logic last, logic empty);
      err_result_t exp_r;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result code=%h found=%b last=%b empty=%b",
                                  code, found, last, empty));
      end else begin
        exp_r = pending_q.pop_front();
        if (code !== exp_r.code)
          report_mismatch($sformatf("code_out %h, expected %h", code, exp_r.code));
        if (found !== exp_r.found)
          report_mismatch($sformatf("found %b, expected %b", found, exp_r.found));
        if (last !== exp_r.last)
          report_mismatch($sformatf("last %b, expected %b", last, exp_r.last));
        if (empty !== exp_r.empty)
          report_mismatch($sformatf("empty_res %b, expected %b", empty, exp_r.empty));
      end
    endtask
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i        = ohes_pkg::OP_STATUS;
  logic [15:0] new_code_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] code_out_o;
  logic        found_o;
  logic        last_o;
  logic        empty_res_o;

  ErrHistScoreboard sb = new();

  bit          in_taken;
  int unsigned burst_left;
  int unsigned cycle_cnt;
  int unsigned stall_tick;
  int unsigned stall_mode;

  overwriting_error_history_stack_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .new_code_i  (new_code_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_out_o  (code_out_o),
    .found_o     (found_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2.0) clk_i = ~clk_i;
  end

  // Transfers on both channels, sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(code_out_o, found_o, last_o, empty_res_o);
      if (in_valid_i && in_ready_o) begin
        sb.note_input(op_i, new_code_i);
        in_taken = 1'b1;
      end
    end
  end

  // Receiver back-pressure in one of four modes, redrawn at random periodically
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 37 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (stall_tick % 4 == 0);
      default: out_ready_i <= (stall_tick % 9 > 5);
    endcase
  end

  task automatic send_item(logic [2:0] op, ohes_pkg::code_t code);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    in_taken = 1'b0;
    in_valid_i <= 1'b1;
    op_i       <= op;
    new_code_i <= code;
    do @(negedge clk_i); while (!in_taken);
    in_taken = 1'b0;
  endtask

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("overwriting_error_history_stack_top_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned push_pct;
    int unsigned roll;
    logic [2:0]  op;

    stall_mode = 0;
    burst_left = 8;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store on every reading operation, plus an unused code
    send_item(ohes_pkg::OP_STATUS, 16'h1234);
    send_item(ohes_pkg::OP_POP,    16'hFFFF);
    send_item(ohes_pkg::OP_PEEK,   16'h0000);
    send_item(ohes_pkg::OP_DUMP,   16'hFFFF);
    send_item(ohes_pkg::OP_READ,   16'h0000);
    send_item(OP_UNUSED,           16'hFFFF);
    // Overfill by one so the oldest code is overwritten
    send_item(ohes_pkg::OP_PUSH, 16'h0000);
    for (int i = 0; i < 15; i++) send_item(ohes_pkg::OP_PUSH, ohes_pkg::code_t'(1) << i);
    send_item(ohes_pkg::OP_PUSH, 16'hFFFF);
    send_item(ohes_pkg::OP_READ, '0);
    send_item(ohes_pkg::OP_PEEK, '0);
    send_item(ohes_pkg::OP_POP,  '0);
    send_item(ohes_pkg::OP_DUMP, '0);
    // Pop down to empty, then clear a non-empty store
    send_item(ohes_pkg::OP_PUSH,   16'hA5A5);
    send_item(ohes_pkg::OP_POP,    '0);
    send_item(ohes_pkg::OP_PUSH,   16'h5A5A);
    send_item(ohes_pkg::OP_CLEAR,  '0);
    send_item(ohes_pkg::OP_STATUS, '0);

    sent     = 0;
    push_pct = 60;
    while (sent < RAND_ITEMS) begin
      if (sent % 25 == 0) push_pct = 30 + 25 * $urandom_range(0, 2);
      if ($urandom_range(0, 99) < push_pct) begin
        op = ohes_pkg::OP_PUSH;
      end else begin
        roll = $urandom_range(0, 19);
        if      (roll < 6)  op = ohes_pkg::OP_POP;
        else if (roll < 10) op = ohes_pkg::OP_PEEK;
        else if (roll < 13) op = ohes_pkg::OP_READ;
        else if (roll < 15) op = ohes_pkg::OP_DUMP;
        else if (roll < 16) op = ohes_pkg::OP_CLEAR;
        else if (roll < 18) op = ohes_pkg::OP_STATUS;
        else                op = OP_UNUSED;
      end
      send_item(op, ohes_pkg::code_t'($urandom));
      if (op != OP_UNUSED) sent++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("overwriting_error_history_stack_top_tb: PASS");
    else
      $display("overwriting_error_history_stack_top_tb: FAIL");
    $finish;
  end

endmodule
